/* rtl/tri_inc_pkg.sv */
// ----------------------------------------------------------------------------
// tri_inc_pkg
// Shared types and constants for the triangle incenter pipeline.
// ----------------------------------------------------------------------------
package tri_inc_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned FracBits  = 8;
  // squared distance of two coordinates
  localparam int unsigned SqBits    = 2 * CoordBits + 2;
  // root of sq * 2^(2*FracBits)
  localparam int unsigned SideBits  = CoordBits + 1 + FracBits;
  localparam int unsigned SqrtSteps = (SqBits + 1) / 2 + FracBits;
  localparam int unsigned RemBits   = SideBits + 2;
  localparam int unsigned PerBits   = SideBits + 2;
  // weighted sum of three vertices
  localparam int unsigned NumBits   = SideBits + CoordBits + 2;
  localparam int unsigned DivBits   = NumBits - 1 + FracBits;
  localparam int unsigned CenterBits = 24;

  typedef struct packed {
    logic signed [CoordBits-1:0] point1_x;
    logic signed [CoordBits-1:0] point1_y;
    logic signed [CoordBits-1:0] point2_x;
    logic signed [CoordBits-1:0] point2_y;
    logic signed [CoordBits-1:0] point3_x;
    logic signed [CoordBits-1:0] point3_y;
  } tri_in_t;

  typedef struct packed {
    logic        [SideBits-1:0]   side_12;
    logic        [SideBits-1:0]   side_23;
    logic        [SideBits-1:0]   side_31;
    logic signed [CenterBits-1:0] center_x;
    logic signed [CenterBits-1:0] center_y;
    logic                         degenerate;
  } tri_out_t;

endpackage

/* rtl/tri_inc_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// tri_inc_sqrt_stage
// One registered step of the digit-by-digit square root, three sides wide.
// ----------------------------------------------------------------------------
module tri_inc_sqrt_stage (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic [2:0][tri_inc_pkg::SqBits-1:0]   sq_i,
  input  logic [2:0][tri_inc_pkg::RemBits-1:0]  rem_i,
  input  logic [2:0][tri_inc_pkg::SideBits-1:0] root_i,
  input  logic [2:0][1:0]                       pair_i,
  output logic [2:0][tri_inc_pkg::SqBits-1:0]   sq_o,
  output logic [2:0][tri_inc_pkg::RemBits-1:0]  rem_o,
  output logic [2:0][tri_inc_pkg::SideBits-1:0] root_o
);

  localparam int unsigned RB = tri_inc_pkg::RemBits;

  logic [2:0][RB-1:0]                       rem_d;
  logic [2:0][tri_inc_pkg::SideBits-1:0]    root_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [RB:0] r;
      logic [RB:0] t;
      r = {rem_i[i][RB-2:0], pair_i[i]};
      t = {root_i[i][RB-3:0], 2'b01};
      if (r >= t) begin
        rem_d[i]  = RB'(r - t);
        root_d[i] = {root_i[i][tri_inc_pkg::SideBits-2:0], 1'b1};
      end else begin
        rem_d[i]  = RB'(r);
        root_d[i] = {root_i[i][tri_inc_pkg::SideBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_o   <= sq_i;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

/* rtl/tri_inc_div_stage.sv */
// ----------------------------------------------------------------------------
// tri_inc_div_stage
// One registered restoring-division step for both centre coordinates.
// ----------------------------------------------------------------------------
module tri_inc_div_stage (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [1:0][tri_inc_pkg::DivBits-1:0] dvd_i,
  input  logic [1:0][tri_inc_pkg::PerBits:0]   rem_i,
  input  logic [tri_inc_pkg::PerBits-1:0]      per_i,
  output logic [1:0][tri_inc_pkg::DivBits-1:0] dvd_o,
  output logic [1:0][tri_inc_pkg::PerBits:0]   rem_o
);

  localparam int unsigned PB = tri_inc_pkg::PerBits;
  localparam int unsigned DB = tri_inc_pkg::DivBits;

  logic [1:0][DB-1:0] dvd_d;
  logic [1:0][PB:0]   rem_d;

  // dividend shifts out at the top while quotient bits enter at the bottom
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      logic [PB+1:0] r;
      r = {rem_i[i], dvd_i[i][DB-1]};
      if (r >= {1'b0, 1'b0, per_i}) begin
        rem_d[i] = (PB+1)'(r - {2'b00, per_i});
        dvd_d[i] = {dvd_i[i][DB-2:0], 1'b1};
      end else begin
        rem_d[i] = (PB+1)'(r);
        dvd_d[i] = {dvd_i[i][DB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_o <= dvd_d;
      rem_o <= rem_d;
    end
  end

endmodule

/* rtl/triangle_incenter.sv */
// ----------------------------------------------------------------------------
// triangle_incenter
// Side lengths and incenter of an integer triangle, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle; the square root and division steps
// each own a register stage, and the whole pipe holds under output stall
// reset: rst_ni clears all valid bits asynchronously; data registers keep
// their contents
module triangle_incenter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tri_inc_pkg::tri_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tri_inc_pkg::tri_out_t out_data_o
);

  localparam int unsigned CB = tri_inc_pkg::CoordBits;
  localparam int unsigned SB = tri_inc_pkg::SqBits;
  localparam int unsigned RB = tri_inc_pkg::RemBits;
  localparam int unsigned SL = tri_inc_pkg::SideBits;
  localparam int unsigned PB = tri_inc_pkg::PerBits;
  localparam int unsigned NB = tri_inc_pkg::NumBits;
  localparam int unsigned DB = tri_inc_pkg::DivBits;
  localparam int unsigned NQ = tri_inc_pkg::SqrtSteps;
  localparam int unsigned FB = tri_inc_pkg::FracBits;
  localparam int unsigned OB = tri_inc_pkg::CenterBits;
  // stages: 0 diff, 1 square, sqrt 2..NQ+1, then weights, sum, DB div steps
  localparam int unsigned NStg = 2 + NQ + 2 + DB;

  logic [NStg-1:0] vld_q;
  logic            adv;

  // one global enable: the whole pipe moves when the output slot frees
  assign adv        = !vld_q[NStg-1] || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], in_valid_i};
    end
  end

  // coordinates travel with the item until the weighting stage
  logic [NQ+1:0][5:0][CB-1:0] pts_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pts_q[0] <= {in_data_i.point1_x, in_data_i.point1_y, in_data_i.point2_x,
                   in_data_i.point2_y, in_data_i.point3_x, in_data_i.point3_y};
      for (int s = 1; s <= NQ + 1; s++) pts_q[s] <= pts_q[s-1];
    end
  end

  // stage 0: differences
  logic [2:0][CB:0] dx_q, dy_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[0] <= (CB+1)'($signed(in_data_i.point2_x) - $signed(in_data_i.point1_x));
      dy_q[0] <= (CB+1)'($signed(in_data_i.point2_y) - $signed(in_data_i.point1_y));
      dx_q[1] <= (CB+1)'($signed(in_data_i.point3_x) - $signed(in_data_i.point2_x));
      dy_q[1] <= (CB+1)'($signed(in_data_i.point3_y) - $signed(in_data_i.point2_y));
      dx_q[2] <= (CB+1)'($signed(in_data_i.point1_x) - $signed(in_data_i.point3_x));
      dy_q[2] <= (CB+1)'($signed(in_data_i.point1_y) - $signed(in_data_i.point3_y));
    end
  end

  // stage 1: squared distances
  logic [NQ:0][2:0][SB-1:0] sq_w;
  logic [NQ:0][2:0][RB-1:0] rem_w;
  logic [NQ:0][2:0][SL-1:0] root_w;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_w[0][i] <= SB'($signed(dx_q[i]) * $signed(dx_q[i]))
                    + SB'($signed(dy_q[i]) * $signed(dy_q[i]));
      end
    end
  end
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;

  // square root: one stage per two-bit digit
  for (genvar g = 0; g < NQ; g++) begin : g_sqrt
    logic [2:0][1:0] pair;
    if (2 * g + 1 < SB) begin : g_pair
      always_comb begin
        for (int i = 0; i < 3; i++) pair[i] = sq_w[g][i][SB-1-2*g -: 2];
      end
    end else if (2 * g < SB) begin : g_pair
      always_comb begin
        for (int i = 0; i < 3; i++) pair[i] = {sq_w[g][i][0], 1'b0};
      end
    end else begin : g_pair
      assign pair = '0;
    end
    tri_inc_sqrt_stage u_sqrt (
      .clk_i  (clk_i),
      .en_i   (adv),
      .sq_i   (sq_w[g]),
      .rem_i  (rem_w[g]),
      .root_i (root_w[g]),
      .pair_i (pair),
      .sq_o   (sq_w[g+1]),
      .rem_o  (rem_w[g+1]),
      .root_o (root_w[g+1])
    );
  end

  logic [2:0][SL-1:0] side_w;
  assign side_w = root_w[NQ];

  // weighted products, one multiplier each
  logic [5:0][NB-1:0] prod_q;
  logic [2:0][SL-1:0] sideb_q;
  logic [PB-1:0]      perb_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // order pts: x1 y1 x2 y2 x3 y3 at indices 5..0
      prod_q[0] <= NB'($signed({1'b0, side_w[0]}) * $signed(pts_q[NQ+1][1]));
      prod_q[1] <= NB'($signed({1'b0, side_w[0]}) * $signed(pts_q[NQ+1][0]));
      prod_q[2] <= NB'($signed({1'b0, side_w[1]}) * $signed(pts_q[NQ+1][5]));
      prod_q[3] <= NB'($signed({1'b0, side_w[1]}) * $signed(pts_q[NQ+1][4]));
      prod_q[4] <= NB'($signed({1'b0, side_w[2]}) * $signed(pts_q[NQ+1][3]));
      prod_q[5] <= NB'($signed({1'b0, side_w[2]}) * $signed(pts_q[NQ+1][2]));
      sideb_q   <= side_w;
      perb_q    <= PB'(side_w[0]) + PB'(side_w[1]) + PB'(side_w[2]);
    end
  end

  // sums and sign split
  logic [DB:0][1:0][DB-1:0] dvd_w;
  logic [DB:0][1:0][PB:0]   drem_w;
  logic [DB:0][1:0]         neg_q;
  logic [DB:0][2:0][SL-1:0] sides_q;
  logic [DB:0][PB-1:0]      per_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 2; c++) begin
        logic [NB-1:0] n;
        logic [NB-1:0] m;
        n = prod_q[c] + prod_q[c+2] + prod_q[c+4];
        m = n[NB-1] ? NB'(-n) : n;
        neg_q[0][c] <= n[NB-1];
        dvd_w[0][c] <= DB'({m, {FB{1'b0}}});
      end
      sides_q[0] <= sideb_q;
      per_q[0]   <= perb_q;
      for (int s = 1; s <= DB; s++) begin
        neg_q[s]   <= neg_q[s-1];
        sides_q[s] <= sides_q[s-1];
        per_q[s]   <= per_q[s-1];
      end
    end
  end
  assign drem_w[0] = '0;

  for (genvar g = 0; g < DB; g++) begin : g_div
    tri_inc_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .dvd_i (dvd_w[g]),
      .rem_i (drem_w[g]),
      .per_i (per_q[g]),
      .dvd_o (dvd_w[g+1]),
      .rem_o (drem_w[g+1])
    );
  end

  logic [1:0][OB-1:0] cen;
  logic               deg;
  always_comb begin
    deg = (per_q[DB] == '0);
    for (int c = 0; c < 2; c++) begin
      if (deg) cen[c] = '0;
      else if (neg_q[DB][c]) cen[c] = OB'(-dvd_w[DB][c]);
      else cen[c] = OB'(dvd_w[DB][c]);
    end
  end

  assign out_valid_o           = vld_q[NStg-1];
  assign out_data_o.side_12    = sides_q[DB][0];
  assign out_data_o.side_23    = sides_q[DB][1];
  assign out_data_o.side_31    = sides_q[DB][2];
  assign out_data_o.center_x   = cen[0];
  assign out_data_o.center_y   = cen[1];
  assign out_data_o.degenerate = deg;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed under stall");
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("pipe stalled with empty output");
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.center_x == '0 && out_data_o.side_12 == '0)
    else $error("degenerate result not cleared");

endmodule
